// ===== sv/tre_pkg.sv =====
// ----------------------------------------------------------------------------
// tre_pkg: shared types and constants of the tone resynthesizer
// Register indexes, waveform codes, datapath widths and the quarter-wave
// sine evaluation used to build the sine table at elaboration.
// ----------------------------------------------------------------------------
package tre_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM    = 3'd6;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SAW    = 2'd1;
  localparam logic [1:0] WAVE_SQUARE = 2'd2;

  // datapath widths
  localparam int COEFF_W = 16;
  localparam int HZ_W    = 16;
  localparam int RATE_W  = 18;
  localparam int FREQ_W  = 24;   // Q16.8 Hz
  localparam int ENV_W   = 24;   // Q1.23
  localparam int HOLD_W  = 26;   // Q18.8 samples

  localparam logic [HOLD_W-1:0] HOLD_MAX  = '1;
  localparam logic [HOLD_W:0]   HOLD_STEP = 27'd256;

  // serial multiplier: signed A times unsigned B, one B bit per cycle
  localparam int MUL_A_W   = 25;
  localparam int MUL_B_W   = 16;
  localparam int MUL_P_W   = MUL_A_W + 1 + MUL_B_W;
  localparam int MUL_CNT_W = 4;

  // serial divider divisor width
  localparam int DSR_W = 24;

  // reset values of the registers
  localparam logic [COEFF_W-1:0] SMOOTHING_RST   = 16'd32768;
  localparam logic [COEFF_W-1:0] ATTACK_RST      = 16'd19661;
  localparam logic [COEFF_W-1:0] RELEASE_RST     = 16'd19661;
  localparam logic [HZ_W-1:0]    FREQ_MIN_RST    = 16'd80;
  localparam logic [HZ_W-1:0]    FREQ_MAX_RST    = 16'd19000;
  localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = 18'd48000;

  typedef logic signed [15:0] sample_t;
  typedef logic [HZ_W-1:0]    hz_t;
  typedef logic [15:0]        level_t;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // sin(pi/2 * r / 2^30) in Q30 for r in [0, 2^30], nested Taylor form
  function automatic logic [63:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    return (x * t) >> 30;
  endfunction

endpackage

// ===== sv/tre_if.sv =====
// ----------------------------------------------------------------------------
// tre_if: item channels of the tone resynthesizer
// Valid/ready channels for audio items in and tone items out.
// ----------------------------------------------------------------------------
interface tre_audio_if;
  import tre_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  hz_t     freq_estimate;
  logic    new_freq;

  modport source (output valid, output sample, output freq_estimate, output new_freq,
                  input ready);
  modport sink (input valid, input sample, input freq_estimate, input new_freq,
                output ready);
endinterface

interface tre_tone_if;
  import tre_pkg::*;

  logic    valid;
  logic    ready;
  sample_t wave_out;
  level_t  envelope_level;
  hz_t     current_freq;

  modport source (output valid, output wave_out, output envelope_level,
                  output current_freq, input ready);
  modport sink (input valid, input wave_out, input envelope_level, input current_freq,
                output ready);
endinterface

// ===== sv/tone_resynth_envelope_osc_core.sv =====
// ----------------------------------------------------------------------------
// tone_resynth_envelope_osc_core: tone resynthesizer top level
// Envelope follower driving a phase-accumulator oscillator (sine, saw,
// square), with a smoothed frequency track and serial arithmetic units.
// ----------------------------------------------------------------------------
// Each audio item carries one sample and, with new_freq set, a frequency
// estimate that is applied first. The block works on one item at a time. An
// item without a frequency update makes two passes of the bit-serial
// multiplier (envelope step, then wave times envelope); the envelope pass is
// skipped while the hold counter runs and the level does not rise. With
// new_freq set, the estimate is first tested, then smoothed with a multiply
// (only when the estimate is in range), and two passes of the restoring
// divider follow (phase step, then hold period), the hold pass being
// skipped at zero frequency. A stalled output holds the block in S_OUT
// until the output register is free.
// A new item is taken while the previous result still waits at the output
// register. Configuration writes land at once and belong in idle time.
// The sine table is a ROM built at elaboration; its read is registered.
// ----------------------------------------------------------------------------
module tone_resynth_envelope_osc_core #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tre_pkg::CFG_DATA_W-1:0] cfg_data,
  tre_audio_if.sink                      audio,
  tre_tone_if.source                     tone
);
  import tre_pkg::*;

  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W  = PHASE_BITS + DEPTH_W;
  // dividend wide enough for f << (PHASE_BITS-8) and for sample_rate << 16
  localparam int DVD_W   = (FREQ_W + PHASE_BITS - 8 > RATE_W + 16) ?
                           FREQ_W + PHASE_BITS - 8 : RATE_W + 16;

  // sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FREQ      = 4'd1;
  localparam logic [3:0] S_SMOOTH    = 4'd2;
  localparam logic [3:0] S_STEP      = 4'd3;
  localparam logic [3:0] S_STEP_WAIT = 4'd4;
  localparam logic [3:0] S_HOLD      = 4'd5;
  localparam logic [3:0] S_HOLD_WAIT = 4'd6;
  localparam logic [3:0] S_PHASE     = 4'd7;
  localparam logic [3:0] S_ENV       = 4'd8;
  localparam logic [3:0] S_ENV_WAIT  = 4'd9;
  localparam logic [3:0] S_WAVE      = 4'd10;
  localparam logic [3:0] S_WAVE_WAIT = 4'd11;
  localparam logic [3:0] S_OUT       = 4'd12;

  // entry k = round(32767 * sin(2*pi*k/depth)), built from the quarter wave
  function automatic logic signed [15:0] sine_entry(input int unsigned k);
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] v;
    logic [1:0]  quad;
    u    = (64'(k) * 64'd4 * Q30_ONE) / 64'(SINE_TABLE_DEPTH);
    quad = u[31:30];
    r    = u & (Q30_ONE - 64'd1);
    s    = quad[0] ? quarter_sine(Q30_ONE - r) : quarter_sine(r);
    v    = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    return quad[1] ? -$signed(v[15:0]) : $signed(v[15:0]);
  endfunction

  // configuration registers
  logic [COEFF_W-1:0] smoothing_coeff;
  logic [COEFF_W-1:0] attack_coeff;
  logic [COEFF_W-1:0] release_coeff;
  logic [HZ_W-1:0]    freq_min;
  logic [HZ_W-1:0]    freq_max;
  logic [RATE_W-1:0]  sample_rate;
  logic [1:0]         waveform;

  // running state
  logic [3:0]            state;
  logic [FREQ_W-1:0]     smoothed_freq;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [PHASE_BITS-1:0] phase_step;
  logic [HOLD_W-1:0]     hold_period;
  logic [HOLD_W-1:0]     hold_count;
  logic [ENV_W-1:0]      envelope;

  // captured item and result
  sample_t sample_r;
  hz_t     estimate_r;
  logic    new_freq_r;
  sample_t wave_res;
  logic    out_valid;
  sample_t out_wave;
  level_t  out_level;
  hz_t     out_freq;

  // serial units
  logic                      mul_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_done;
  logic signed [MUL_P_W-1:0] mul_p;
  logic                      div_start;
  logic [DVD_W-1:0]          div_dividend;
  logic [DSR_W-1:0]          div_divisor;
  logic                      div_done;
  logic [DVD_W-1:0]          div_q;

  // sine ROM
  logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];
  logic signed [15:0] rom_data;
  logic [PROD_W-1:0]  idx_prod;
  logic [IDX_W-1:0]   rom_idx;

  // combinational helpers
  logic [15:0]              sample_mag;
  logic [ENV_W-1:0]         mag;
  logic signed [MUL_A_W-1:0] env_diff;
  logic signed [MUL_A_W-1:0] freq_diff;
  logic signed [MUL_A_W:0]  mul_floor16;
  logic signed [MUL_A_W:0]  env_upd;
  logic signed [MUL_A_W:0]  freq_upd;
  logic [HOLD_W:0]          hold_sum;
  logic [HOLD_W-1:0]        hold_inc;
  logic signed [15:0]       wave;
  logic signed [MUL_A_W+1:0] scaled;
  logic                     in_range;
  logic [RATE_W-1:0]        rate_nz;

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k);
  end

  // sine index = floor(phase * depth / 2^PHASE_BITS)
  assign idx_prod = PROD_W'(phase_acc) * PROD_W'(SINE_TABLE_DEPTH);
  assign rom_idx  = idx_prod[PHASE_BITS +: IDX_W];

  always_ff @(posedge clk) begin
    rom_data <= sine_rom[rom_idx];
  end

  tre_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  tre_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // |sample| in Q1.23; -32768 maps to 2^23
  assign sample_mag = sample_r[15] ? 16'(-sample_r) : 16'(sample_r);
  assign mag        = {sample_mag, 8'h00};
  assign env_diff   = $signed({1'b0, mag}) - $signed({1'b0, envelope});
  assign freq_diff  = $signed({1'b0, estimate_r, 8'h00}) - $signed({1'b0, smoothed_freq});

  // arithmetic shift of the product is the floor of c*d/65536
  assign mul_floor16 = mul_p[MUL_P_W-1:16];
  assign env_upd     = $signed({2'b00, envelope}) + mul_floor16;
  assign freq_upd    = $signed({2'b00, smoothed_freq}) + mul_floor16;
  assign scaled      = mul_p[MUL_P_W-1:15];

  // count up by one sample, saturating at the top of the counter
  assign hold_sum = {1'b0, hold_count} + HOLD_STEP;
  assign hold_inc = hold_sum[HOLD_W] ? HOLD_MAX : hold_sum[HOLD_W-1:0];

  // a reversed range accepts nothing
  assign in_range = (estimate_r >= freq_min) && (estimate_r <= freq_max);
  assign rate_nz  = (sample_rate == '0) ? RATE_W'(1) : sample_rate;

  always_comb begin
    case (waveform)
      WAVE_SINE:   wave = rom_data;
      WAVE_SAW:    wave = $signed(phase_acc[PHASE_BITS-1 -: 16]);
      WAVE_SQUARE: wave = phase_acc[PHASE_BITS-1] ? -16'sd32768 : 16'sd32767;
      default:     wave = '0;
    endcase
  end

  // configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_coeff <= SMOOTHING_RST;
      attack_coeff    <= ATTACK_RST;
      release_coeff   <= RELEASE_RST;
      freq_min        <= FREQ_MIN_RST;
      freq_max        <= FREQ_MAX_RST;
      sample_rate     <= SAMPLE_RATE_RST;
      waveform        <= WAVE_SINE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SMOOTHING:   smoothing_coeff <= cfg_data[COEFF_W-1:0];
        REG_ATTACK:      attack_coeff    <= cfg_data[COEFF_W-1:0];
        REG_RELEASE:     release_coeff   <= cfg_data[COEFF_W-1:0];
        REG_FREQ_MIN:    freq_min        <= cfg_data[HZ_W-1:0];
        REG_FREQ_MAX:    freq_max        <= cfg_data[HZ_W-1:0];
        REG_SAMPLE_RATE: sample_rate     <= cfg_data[RATE_W-1:0];
        REG_WAVEFORM:    waveform        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign audio.ready         = (state == S_IDLE);
  assign tone.valid          = out_valid;
  assign tone.wave_out       = out_wave;
  assign tone.envelope_level = out_level;
  assign tone.current_freq   = out_freq;

  // sequencer and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      smoothed_freq <= '0;
      phase_acc     <= '0;
      phase_step    <= '0;
      hold_period   <= '0;
      hold_count    <= '0;
      envelope      <= '0;
      out_valid     <= 1'b0;
      mul_start     <= 1'b0;
      div_start     <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      // load a finished item into a free output register, else drop a taken one
      if (state == S_OUT && (!out_valid || tone.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && tone.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (audio.valid) begin
            state <= audio.new_freq ? S_FREQ : S_PHASE;
          end
        end
        S_FREQ: begin
          // smooth an accepted estimate; a rejected one still re-derives rates
          if (in_range) begin
            mul_a     <= freq_diff;
            mul_b     <= smoothing_coeff;
            mul_start <= 1'b1;
            state     <= S_SMOOTH;
          end else begin
            state <= S_STEP;
          end
        end
        S_SMOOTH: begin
          if (mul_done) begin
            smoothed_freq <= freq_upd[FREQ_W-1:0];
            state         <= S_STEP;
          end
        end
        S_STEP: begin
          // phase step = floor(f * 2^(PHASE_BITS-8) / sample_rate)
          div_dividend <= DVD_W'(smoothed_freq) << (PHASE_BITS - 8);
          div_divisor  <= DSR_W'(rate_nz);
          div_start    <= 1'b1;
          state        <= S_STEP_WAIT;
        end
        S_STEP_WAIT: begin
          if (div_done) begin
            phase_step <= div_q[PHASE_BITS-1:0];
            state      <= S_HOLD;
          end
        end
        S_HOLD: begin
          // hold = floor(sample_rate * 65536 / f), saturating; zero f holds longest
          if (smoothed_freq == '0) begin
            hold_period <= HOLD_MAX;
            state       <= S_PHASE;
          end else begin
            div_dividend <= DVD_W'(sample_rate) << 16;
            div_divisor  <= DSR_W'(smoothed_freq);
            div_start    <= 1'b1;
            state        <= S_HOLD_WAIT;
          end
        end
        S_HOLD_WAIT: begin
          if (div_done) begin
            hold_period <= (div_q > DVD_W'(HOLD_MAX)) ? HOLD_MAX : div_q[HOLD_W-1:0];
            state       <= S_PHASE;
          end
        end
        S_PHASE: begin
          phase_acc <= phase_acc + phase_step;
          state     <= S_ENV;
        end
        S_ENV: begin
          // attack at once on a rise; on a fall, release once per hold period
          if (envelope < mag) begin
            mul_a      <= env_diff;
            mul_b      <= attack_coeff;
            mul_start  <= 1'b1;
            hold_count <= '0;
            state      <= S_ENV_WAIT;
          end else if (hold_count < hold_period) begin
            hold_count <= hold_inc;
            state      <= S_WAVE;
          end else begin
            mul_a      <= env_diff;
            mul_b      <= release_coeff;
            mul_start  <= 1'b1;
            hold_count <= hold_count - hold_period;
            state      <= S_ENV_WAIT;
          end
        end
        S_ENV_WAIT: begin
          if (mul_done) begin
            envelope <= env_upd[ENV_W-1:0];
            state    <= S_WAVE;
          end
        end
        S_WAVE: begin
          mul_a     <= {{(MUL_A_W-16){wave[15]}}, wave};
          mul_b     <= envelope[ENV_W-1 -: MUL_B_W];
          mul_start <= 1'b1;
          state     <= S_WAVE_WAIT;
        end
        S_WAVE_WAIT: begin
          if (mul_done) begin
            if (scaled > 27'sd32767) begin
              wave_res <= 16'sd32767;
            end else if (scaled < -27'sd32768) begin
              wave_res <= -16'sd32768;
            end else begin
              wave_res <= scaled[15:0];
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || tone.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // capture the item and the result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && audio.valid) begin
      sample_r   <= audio.sample;
      estimate_r <= audio.freq_estimate;
      new_freq_r <= audio.new_freq;
    end
    if (state == S_OUT && (!out_valid || tone.ready)) begin
      out_wave  <= wave_res;
      out_level <= envelope[ENV_W-1 -: 16];
      out_freq  <= new_freq_r ? smoothed_freq[FREQ_W-1 -: 16] : smoothed_freq[FREQ_W-1 -: 16];
    end
  end

endmodule

// ===== sv/tre_mul.sv =====
// ----------------------------------------------------------------------------
// tre_mul: bit-serial multiplier
// Signed A times unsigned B, one bit of B per cycle, right-shifting
// accumulator; the product is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module tre_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [tre_pkg::MUL_A_W-1:0] a,
  input  logic        [tre_pkg::MUL_B_W-1:0] b,
  output logic                               done,
  output logic signed [tre_pkg::MUL_P_W-1:0] product
);
  import tre_pkg::*;

  logic                        busy;
  logic [MUL_CNT_W-1:0]        cnt;
  logic signed [MUL_A_W-1:0]   a_r;
  logic signed [MUL_A_W:0]     hi;
  logic [MUL_B_W-1:0]          lo;
  logic signed [MUL_A_W:0]     sum;

  assign sum     = lo[0] ? hi + {a_r[MUL_A_W-1], a_r} : hi;
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      hi  <= '0;
      lo  <= b;
    end else if (busy) begin
      // add on the low multiplier bit, then shift one place right
      hi <= sum >>> 1;
      lo <= {sum[0], lo[MUL_B_W-1:1]};
    end
  end

endmodule

// ===== sv/tre_div.sv =====
// ----------------------------------------------------------------------------
// tre_div: restoring divider
// One quotient bit per cycle; the quotient is valid in the cycle that done
// is high.
// ----------------------------------------------------------------------------
module tre_div #(
  parameter int DVD_W = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DVD_W-1:0]          dividend,
  input  logic [tre_pkg::DSR_W-1:0] divisor,
  output logic                      done,
  output logic [DVD_W-1:0]          quotient
);
  import tre_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dq;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W-1:0] rem;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W+1:0] diff;
  logic             fits;

  assign rem_sh   = {rem, dq[DVD_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dsr_r};
  assign fits     = ~diff[DSR_W+1];
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq    <= dividend;
      dsr_r <= divisor;
      rem   <= '0;
    end else if (busy) begin
      rem <= fits ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      dq  <= {dq[DVD_W-2:0], fits};
    end
  end

endmodule

// ===== sv/tre_checker.sv =====
// ----------------------------------------------------------------------------
// tre_checker: port-level checks of the tone resynthesizer
// Watches the item channels and checks acceptance, occupancy, stall hold and result range.
// ----------------------------------------------------------------------------
module tre_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] wave_out,
  input logic [15:0] envelope_level,
  input logic [15:0] current_freq
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input taken again while an item is in work");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> pending == 2'd0 || pending == 2'd1)
    else $error("item taken with two items outstanding");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result shown with no item outstanding");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(wave_out)
      && $stable(envelope_level) && $stable(current_freq))
    else $error("stalled result changed");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> envelope_level <= 16'd32768)
    else $error("envelope level above unity");

endmodule

bind tone_resynth_envelope_osc_core tre_checker u_tre_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (audio.valid),
  .in_ready       (audio.ready),
  .out_valid      (tone.valid),
  .out_ready      (tone.ready),
  .wave_out       (tone.wave_out),
  .envelope_level (tone.envelope_level),
  .current_freq   (tone.current_freq)
);
